/* src/nhps_pkg.sv */
// Shared constants and types for the noisy heading particle step pipeline.
// No dependencies; used by noisy_heading_particle_step.
`default_nettype none
package nhps_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // vectoring datapath, angle and rotation datapath widths
    localparam int VW = 45;
    localparam int AW = 36;
    localparam int RW = FRAC_BITS + 4;

    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint TWO_PI_Q30   = 64'sd6746518852;
    localparam longint GAIN_INV_Q30 = 64'sd652032874;
    localparam longint GAIN_ROT =
        (GAIN_INV_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

    localparam int HALF_Q16 = 32768;
    localparam int ONE_Q16  = 65536;
    localparam int NORM_MSB = 40;

    localparam int SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam longint RND = (FRAC_BITS > 16) ? (64'sd1 <<< (SHR - 1)) : 64'sd0;

    localparam longint ATAN_TAB [0:TABLE_LEN-1] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    // stage numbering: capture, flip, msb search, normalize, vectoring,
    // angle sum, two wraps, rotation, clamp, product, round, position wrap
    localparam int ST_VEC = 4;
    localparam int ST_ANG = ST_VEC + NS;
    localparam int ST_ROT = ST_ANG + 3;
    localparam int LAT    = ST_ROT + NS + 4;

    typedef enum logic [1:0] {
        t_REG_BOX_WIDTH  = 2'd0,
        t_REG_BOX_HEIGHT = 2'd1,
        t_REG_SPEED      = 2'd2,
        t_REG_BIDIR      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic signed [18:0] noise;
        logic [15:0]        coin;
    } t_side;

endpackage
`default_nettype wire

/* src/noisy_heading_particle_step.sv */
// Noisy heading particle step: pipelined vectoring CORDIC, noise add, rotation
// CORDIC, speed scaling and periodic wrap. Depends on nhps_pkg.
`default_nettype none

// One particle enters per clock while busy is low (busy is high only in
// reset). Each result appears on o_new_x/o_new_y/o_heading_x/o_heading_y for
// one cycle with o_strobe, once its request has passed through every pipeline
// stage; the depth is set by one CORDIC iteration per stage. Results cannot be
// held off. Write configuration only while no request is in flight;
// o_cfg_ready is always high.
module noisy_heading_particle_step (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [31:0]  i_pos_x,
    input  wire logic [31:0]  i_pos_y,
    input  wire logic signed [23:0] i_vel_x,
    input  wire logic signed [23:0] i_vel_y,
    input  wire logic signed [18:0] i_noise_angle,
    input  wire logic [15:0]  i_coin,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output logic              o_strobe,
    output logic [31:0]       o_new_x,
    output logic [31:0]       o_new_y,
    output logic signed [17:0] o_heading_x,
    output logic signed [17:0] o_heading_y
);
    localparam int NS  = nhps_pkg::NS;
    localparam int VW  = nhps_pkg::VW;
    localparam int AW  = nhps_pkg::AW;
    localparam int RW  = nhps_pkg::RW;
    localparam int LAT = nhps_pkg::LAT;

    logic [31:0] r_box_w, r_box_h;
    logic [16:0] r_speed;
    logic        r_bidir;

    logic              accept;
    logic [LAT:1]      r_vld;
    nhps_pkg::t_side   r_side [1:LAT-1];

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= 32'd2097152;
            r_box_h <= 32'd2097152;
            r_speed <= 17'd32768;
            r_bidir <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (nhps_pkg::t_cfg_index'(i_cfg_index))
                nhps_pkg::t_REG_BOX_WIDTH:  r_box_w <= i_cfg_data;
                nhps_pkg::t_REG_BOX_HEIGHT: r_box_h <= i_cfg_data;
                nhps_pkg::t_REG_SPEED:      r_speed <= i_cfg_data[16:0];
                nhps_pkg::t_REG_BIDIR:      r_bidir <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits and side payload travel together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[1] <= '{pos_x: i_pos_x, pos_y: i_pos_y,
                       noise: i_noise_angle, coin: i_coin};
        for (int k = 2; k < LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // stage 1: capture velocity
    logic signed [23:0] r1_vx, r1_vy;
    always_ff @(posedge i_clk) begin
        r1_vx <= i_vel_x;
        r1_vy <= i_vel_y;
    end

    // stage 2: fold into right half plane
    logic signed [24:0] r2_x, r2_y;
    logic               r2_flip, r2_zero;
    always_ff @(posedge i_clk) begin
        r2_flip <= r1_vx[23];
        r2_zero <= (r1_vx == '0) && (r1_vy == '0);
        r2_x    <= r1_vx[23] ? -25'(r1_vx) : 25'(r1_vx);
        r2_y    <= r1_vx[23] ? -25'(r1_vy) : 25'(r1_vy);
    end

    // stage 3: find leading one of the larger magnitude
    logic [24:0] s3_ay, s3_big;
    logic [5:0]  s3_shift;
    logic signed [24:0] r3_x, r3_y;
    logic        r3_flip, r3_zero;
    logic [5:0]  r3_shift;
    always_comb begin
        s3_ay    = r2_y[24] ? 25'(-r2_y) : 25'(r2_y);
        s3_big   = (25'(r2_x) > s3_ay) ? 25'(r2_x) : s3_ay;
        s3_shift = 6'(nhps_pkg::NORM_MSB);
        for (int b = 0; b < 25; b++) begin
            if (s3_big[b]) s3_shift = 6'(nhps_pkg::NORM_MSB - b);
        end
    end
    always_ff @(posedge i_clk) begin
        r3_x     <= r2_x;
        r3_y     <= r2_y;
        r3_flip  <= r2_flip;
        r3_zero  <= r2_zero;
        r3_shift <= s3_shift;
    end

    // stage 4 and vectoring iterations
    logic signed [VW-1:0] r_vx [0:NS];
    logic signed [VW-1:0] r_vy [0:NS];
    logic signed [AW-1:0] r_vz [0:NS];
    logic                 r_vzero [0:NS];

    always_ff @(posedge i_clk) begin
        r_vx[0]    <= VW'(r3_x) <<< r3_shift;
        r_vy[0]    <= VW'(r3_y) <<< r3_shift;
        r_vz[0]    <= r3_flip ? AW'(nhps_pkg::PI_Q30) : '0;
        r_vzero[0] <= r3_zero;
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_vec
        localparam logic signed [AW-1:0] ATAN = AW'(nhps_pkg::ATAN_TAB[gi]);
        always_ff @(posedge i_clk) begin
            r_vzero[gi+1] <= r_vzero[gi];
            if (r_vy[gi] > 0) begin
                r_vx[gi+1] <= r_vx[gi] + (r_vy[gi] >>> gi);
                r_vy[gi+1] <= r_vy[gi] - (r_vx[gi] >>> gi);
                r_vz[gi+1] <= r_vz[gi] + ATAN;
            end else begin
                r_vx[gi+1] <= r_vx[gi] - (r_vy[gi] >>> gi);
                r_vy[gi+1] <= r_vy[gi] + (r_vx[gi] >>> gi);
                r_vz[gi+1] <= r_vz[gi] - ATAN;
            end
        end
    end

    // add noise, bring into [-pi, pi] in two steps, fold beyond +-pi/2
    localparam logic signed [AW-1:0] PI_A   = AW'(nhps_pkg::PI_Q30);
    localparam logic signed [AW-1:0] HPI_A  = AW'(nhps_pkg::HALF_PI_Q30);
    localparam logic signed [AW-1:0] TWOPI_A = AW'(nhps_pkg::TWO_PI_Q30);

    logic signed [AW-1:0] ra1, ra2, ra3;
    logic                 ra3_neg;
    always_ff @(posedge i_clk) begin
        ra1 <= (r_vzero[NS] ? '0 : r_vz[NS])
             + (AW'(r_side[nhps_pkg::ST_ANG].noise) <<< 14);
    end
    always_ff @(posedge i_clk) begin
        if (ra1 > PI_A)       ra2 <= ra1 - TWOPI_A;
        else if (ra1 < -PI_A) ra2 <= ra1 + TWOPI_A;
        else                  ra2 <= ra1;
    end
    logic signed [AW-1:0] s_a3;
    always_comb begin
        if (ra2 > PI_A)       s_a3 = ra2 - TWOPI_A;
        else if (ra2 < -PI_A) s_a3 = ra2 + TWOPI_A;
        else                  s_a3 = ra2;
    end
    always_ff @(posedge i_clk) begin
        ra3_neg <= (s_a3 > HPI_A) || (s_a3 < -HPI_A);
        if (s_a3 > HPI_A)       ra3 <= s_a3 - PI_A;
        else if (s_a3 < -HPI_A) ra3 <= s_a3 + PI_A;
        else                    ra3 <= s_a3;
    end

    // rotation iterations
    localparam logic signed [RW-1:0] GAIN = RW'(nhps_pkg::GAIN_ROT);
    logic signed [RW-1:0] r_rx [0:NS];
    logic signed [RW-1:0] r_ry [0:NS];
    logic signed [AW-1:0] r_rz [0:NS];

    assign r_rx[0] = ra3_neg ? -GAIN : GAIN;
    assign r_ry[0] = '0;
    assign r_rz[0] = ra3;

    for (genvar gr = 0; gr < NS; gr++) begin : g_rot
        localparam logic signed [AW-1:0] ATAN = AW'(nhps_pkg::ATAN_TAB[gr]);
        always_ff @(posedge i_clk) begin
            if (r_rz[gr] >= 0) begin
                r_rx[gr+1] <= r_rx[gr] - (r_ry[gr] >>> gr);
                r_ry[gr+1] <= r_ry[gr] + (r_rx[gr] >>> gr);
                r_rz[gr+1] <= r_rz[gr] - ATAN;
            end else begin
                r_rx[gr+1] <= r_rx[gr] + (r_ry[gr] >>> gr);
                r_ry[gr+1] <= r_ry[gr] - (r_rx[gr] >>> gr);
                r_rz[gr+1] <= r_rz[gr] + ATAN;
            end
        end
    end

    // rescale to Q.16 and clamp
    logic signed [39:0] s_tx, s_ty;
    logic signed [17:0] rh1_x, rh1_y;
    always_comb begin
        if (nhps_pkg::FRAC_BITS > 16) begin
            s_tx = (40'(r_rx[NS]) + 40'(nhps_pkg::RND)) >>> nhps_pkg::SHR;
            s_ty = (40'(r_ry[NS]) + 40'(nhps_pkg::RND)) >>> nhps_pkg::SHR;
        end else begin
            s_tx = 40'(r_rx[NS]) <<< nhps_pkg::SHL;
            s_ty = 40'(r_ry[NS]) <<< nhps_pkg::SHL;
        end
    end
    always_ff @(posedge i_clk) begin
        if (s_tx > 40'sd65536)       rh1_x <= 18'sd65536;
        else if (s_tx < -40'sd65536) rh1_x <= -18'sd65536;
        else                         rh1_x <= s_tx[17:0];
        if (s_ty > 40'sd65536)       rh1_y <= 18'sd65536;
        else if (s_ty < -40'sd65536) rh1_y <= -18'sd65536;
        else                         rh1_y <= s_ty[17:0];
    end

    // scale by speed
    logic signed [17:0] s_spd;
    logic signed [35:0] rp_x, rp_y;
    logic signed [17:0] rh2_x, rh2_y;
    assign s_spd = (r_speed > 17'(nhps_pkg::ONE_Q16)) ? 18'sd65536 : 18'(r_speed);
    always_ff @(posedge i_clk) begin
        rp_x  <= s_spd * rh1_x;
        rp_y  <= s_spd * rh1_y;
        rh2_x <= rh1_x;
        rh2_y <= rh1_y;
    end

    // round, pick direction
    logic signed [35:0] s_dx, s_dy;
    logic               s_fwd;
    logic signed [19:0] rd_x, rd_y;
    logic signed [17:0] rh3_x, rh3_y;
    always_comb begin
        s_dx  = (rp_x + 36'sd32768) >>> 16;
        s_dy  = (rp_y + 36'sd32768) >>> 16;
        s_fwd = !r_bidir
              || (r_side[LAT-2].coin > 16'(nhps_pkg::HALF_Q16));
    end
    always_ff @(posedge i_clk) begin
        rd_x  <= s_fwd ? s_dx[19:0] : -s_dx[19:0];
        rd_y  <= s_fwd ? s_dy[19:0] : -s_dy[19:0];
        rh3_x <= rh2_x;
        rh3_y <= rh2_y;
    end

    // single periodic wrap per axis
    logic signed [34:0] s_px, s_py, s_bw, s_bh, s_wx, s_wy;
    always_comb begin
        s_px = 35'({1'b0, r_side[LAT-1].pos_x}) + 35'(rd_x);
        s_py = 35'({1'b0, r_side[LAT-1].pos_y}) + 35'(rd_y);
        s_bw = 35'({1'b0, r_box_w});
        s_bh = 35'({1'b0, r_box_h});
        if (s_px >= s_bw)   s_wx = s_px - s_bw;
        else if (s_px < 0)  s_wx = s_px + s_bw;
        else                s_wx = s_px;
        if (s_py >= s_bh)   s_wy = s_py - s_bh;
        else if (s_py < 0)  s_wy = s_py + s_bh;
        else                s_wy = s_py;
    end
    always_ff @(posedge i_clk) begin
        o_new_x     <= s_wx[31:0];
        o_new_y     <= s_wy[31:0];
        o_heading_x <= rh3_x;
        o_heading_y <= rh3_y;
    end
    assign o_strobe = r_vld[LAT];

    // every request yields a strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("missing result after request");

    a_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_heading_x <= 18'sd65536) && (o_heading_x >= -18'sd65536)
                  && (o_heading_y <= 18'sd65536) && (o_heading_y >= -18'sd65536))
        else $error("heading out of unit range");

endmodule
`default_nettype wire
